>>> hdl/bfpa_pkg.sv
package bfpa_pkg;

   // Default table depth
   localparam int NUM_PARTITIONS_DEF = 8;

   // Field widths
   localparam int OP_W   = 2;
   localparam int PIDX_W = 3;
   localparam int WORD_W = 20;
   localparam int PID_W  = 8;
   localparam int STS_W  = 2;
   localparam int MASK_W = 8;

   // Item opcodes
   localparam logic [OP_W-1:0] OP_DEFINE   = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE  = 2'd2;

   // Result status codes
   localparam logic [STS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STS_W-1:0] ST_MEMORY_FULL = 2'd1;
   localparam logic [STS_W-1:0] ST_TOO_BIG     = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [PIDX_W-1:0] partition_index;
      logic [WORD_W-1:0] partition_size;
      logic [WORD_W-1:0] partition_base;
      logic [WORD_W-1:0] request_size;
      logic [PID_W-1:0]  process_id;
   } req_type;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic [PIDX_W-1:0] granted_index;
      logic [WORD_W-1:0] granted_base;
      logic [MASK_W-1:0] released_mask;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEFINE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // latch the accepted request, restart the scan
      logic define_wr;  // write size and base of one partition
      logic issue;      // read the next table row
      logic finish;     // commit the grant and load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_last;  // the row being issued is the last one
      logic out_free;   // result register can take a new beat
   } sts_type;

endpackage

>>> hdl/best_fit_partition_allocator.sv
// Best-fit fixed-partition allocator.
// Input channel req_valid/req_ready/req_data carries one item per beat:
// define (write size and base of one partition), allocate (take the smallest
// free partition that holds request_size, lowest index on ties) or release
// (free every occupied partition owned by process_id).
// Result channel rsp_valid/rsp_ready/rsp_data returns exactly one beat per
// item: status, granted_index, granted_base and released_mask.
// From accept to result: define passes S_DEFINE and S_FINISH, allocate and
// release pass S_SCAN over every row, S_DRAIN and S_FINISH, other opcodes go
// to S_FINISH alone. The allocate and release scan reads one table row per
// cycle through the single read port of the partition table.
// One item is in flight at a time; req_ready is high whenever no item is in
// work, even while a finished result still waits in the output register.
// If the receiver stalls, the result register holds its beat and the next
// item finishes its work and then waits until the register is taken.
// Synchronous reset clears all partitions to size 0, base 0 and free, and
// empties the result register; the block is ready in the cycle after reset.
module best_fit_partition_allocator #(
   parameter int NUM_PARTITIONS = bfpa_pkg::NUM_PARTITIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bfpa_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bfpa_pkg::rsp_type  rsp_data
);

   bfpa_pkg::cmd_type cmd;
   bfpa_pkg::sts_type sts;

   // Sequence the item
   bfpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .sts        (sts),
      .req_ready  (req_ready),
      .cmd        (cmd)
   );

   // Hold the table and build the result
   bfpa_dpath #(
      .NUM_PARTITIONS (NUM_PARTITIONS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hdl/bfpa_ctrl.sv
module bfpa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_opcode,
   input  bfpa_pkg::sts_type  sts,
   output logic               req_ready,
   output bfpa_pkg::cmd_type  cmd
);

   bfpa_pkg::state_type state_ff;
   bfpa_pkg::state_type state_in;

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfpa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pick the next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfpa_pkg::S_IDLE: begin
            if (req_valid) begin
               priority if (req_opcode == bfpa_pkg::OP_DEFINE) begin
                  state_in = bfpa_pkg::S_DEFINE;
               end else if (req_opcode == bfpa_pkg::OP_ALLOCATE ||
                            req_opcode == bfpa_pkg::OP_RELEASE) begin
                  state_in = bfpa_pkg::S_SCAN;
               end else begin
                  state_in = bfpa_pkg::S_FINISH;
               end
            end
         end
         bfpa_pkg::S_DEFINE: begin
            state_in = bfpa_pkg::S_FINISH;
         end
         bfpa_pkg::S_SCAN: begin
            if (sts.scan_last) begin
               state_in = bfpa_pkg::S_DRAIN;
            end
         end
         bfpa_pkg::S_DRAIN: begin
            state_in = bfpa_pkg::S_FINISH;
         end
         bfpa_pkg::S_FINISH: begin
            if (sts.out_free) begin
               state_in = bfpa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bfpa_pkg::S_IDLE;
         end
      endcase
   end

   // Drive the commands
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         bfpa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         bfpa_pkg::S_DEFINE: begin
            cmd.define_wr = 1'b1;
         end
         bfpa_pkg::S_SCAN: begin
            cmd.issue = 1'b1;
         end
         bfpa_pkg::S_DRAIN: begin
         end
         bfpa_pkg::S_FINISH: begin
            cmd.finish = sts.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> hdl/bfpa_dpath.sv
module bfpa_dpath #(
   parameter int NUM_PARTITIONS = bfpa_pkg::NUM_PARTITIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  bfpa_pkg::req_type  req_data,
   input  bfpa_pkg::cmd_type  cmd,
   output bfpa_pkg::sts_type  sts,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bfpa_pkg::rsp_type  rsp_data
);

   localparam int IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
   localparam int CW = $clog2(NUM_PARTITIONS + 1);
   localparam int WW = bfpa_pkg::WORD_W;

   // Partition table
   logic [WW-1:0]              size_mem  [NUM_PARTITIONS];
   logic [WW-1:0]              base_mem  [NUM_PARTITIONS];
   logic [bfpa_pkg::PID_W-1:0] owner_mem [NUM_PARTITIONS];

   logic [WW-1:0]              size_rd_ff;
   logic [WW-1:0]              base_rd_ff;
   logic [bfpa_pkg::PID_W-1:0] owner_rd_ff;

   bfpa_pkg::req_type   req_ff,       req_in;
   logic [CW-1:0]       rd_cnt_ff,    rd_cnt_in;
   logic                ev_vld_ff,    ev_vld_in;
   logic [IW-1:0]       ev_idx_ff,    ev_idx_in;
   logic [NUM_PARTITIONS-1:0] busy_ff, busy_in;
   logic [NUM_PARTITIONS-1:0] defd_ff, defd_in;
   logic [NUM_PARTITIONS-1:0] rmask_ff, rmask_in;
   logic                best_vld_ff,  best_vld_in;
   logic [IW-1:0]       best_idx_ff,  best_idx_in;
   logic [WW-1:0]       best_size_ff, best_size_in;
   logic [WW-1:0]       best_base_ff, best_base_in;
   logic                full_fit_ff,  full_fit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   bfpa_pkg::rsp_type   rsp_data_ff,  rsp_data_in;

   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_idx;
   logic          in_range;
   logic [WW-1:0] size_eff;
   logic [WW-1:0] base_eff;
   logic          fits;
   logic          is_alloc;
   logic          is_release;
   logic          grant;

   assign rd_addr    = rd_cnt_ff[IW-1:0];
   assign wr_idx     = IW'(req_ff.partition_index);
   assign in_range   = 32'(req_ff.partition_index) < 32'(NUM_PARTITIONS);
   assign is_alloc   = req_ff.opcode == bfpa_pkg::OP_ALLOCATE;
   assign is_release = req_ff.opcode == bfpa_pkg::OP_RELEASE;
   assign grant      = cmd.finish && is_alloc && best_vld_ff;

   // Rows never defined read as zero
   assign size_eff = defd_ff[ev_idx_ff] ? size_rd_ff : '0;
   assign base_eff = defd_ff[ev_idx_ff] ? base_rd_ff : '0;
   assign fits     = req_ff.request_size <= size_eff;

   assign sts.scan_last = rd_cnt_ff == CW'(NUM_PARTITIONS - 1);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Table memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (cmd.define_wr && in_range) begin
         size_mem[wr_idx] <= req_ff.partition_size;
         base_mem[wr_idx] <= req_ff.partition_base;
      end
      if (grant) begin
         owner_mem[best_idx_ff] <= req_ff.process_id;
      end
      if (cmd.issue) begin
         size_rd_ff  <= size_mem[rd_addr];
         base_rd_ff  <= base_mem[rd_addr];
         owner_rd_ff <= owner_mem[rd_addr];
      end
   end

   // Scan, evaluate one row a cycle, commit and build the result
   always_comb begin
      req_in       = req_ff;
      rd_cnt_in    = rd_cnt_ff;
      ev_vld_in    = 1'b0;
      ev_idx_in    = ev_idx_ff;
      busy_in      = busy_ff;
      defd_in      = defd_ff;
      rmask_in     = rmask_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_size_in = best_size_ff;
      best_base_in = best_base_ff;
      full_fit_in  = full_fit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         req_in      = req_data;
         rd_cnt_in   = '0;
         best_vld_in = 1'b0;
         full_fit_in = 1'b0;
         rmask_in    = '0;
      end

      if (cmd.issue) begin
         rd_cnt_in = rd_cnt_ff + CW'(1);
         ev_vld_in = 1'b1;
         ev_idx_in = rd_addr;
      end

      if (ev_vld_ff) begin
         if (is_alloc && fits) begin
            if (busy_ff[ev_idx_ff]) begin
               full_fit_in = 1'b1;
            end else if (!best_vld_ff || size_eff < best_size_ff) begin
               best_vld_in  = 1'b1;
               best_idx_in  = ev_idx_ff;
               best_size_in = size_eff;
               best_base_in = base_eff;
            end
         end
         if (is_release && busy_ff[ev_idx_ff] && owner_rd_ff == req_ff.process_id) begin
            busy_in[ev_idx_ff]  = 1'b0;
            rmask_in[ev_idx_ff] = 1'b1;
         end
      end

      if (cmd.define_wr && in_range) begin
         defd_in[wr_idx] = 1'b1;
      end

      if (grant) begin
         busy_in[best_idx_ff] = 1'b1;
      end

      // Drop the beat once taken, load a fresh one on finish
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in.status = bfpa_pkg::ST_OK;
         if (is_alloc) begin
            priority if (best_vld_ff) begin
               rsp_data_in.granted_index = bfpa_pkg::PIDX_W'(best_idx_ff);
               rsp_data_in.granted_base  = best_base_ff;
            end else if (full_fit_ff) begin
               rsp_data_in.status = bfpa_pkg::ST_MEMORY_FULL;
            end else begin
               rsp_data_in.status = bfpa_pkg::ST_TOO_BIG;
            end
         end else if (is_release) begin
            rsp_data_in.released_mask = bfpa_pkg::MASK_W'(rmask_ff);
         end
      end
   end

   // Control state takes reset, payload does not
   always_ff @(posedge clock) begin
      if (reset) begin
         ev_vld_ff    <= 1'b0;
         busy_ff      <= '0;
         defd_ff      <= '0;
         best_vld_ff  <= 1'b0;
         full_fit_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_cnt_ff    <= '0;
      end else begin
         ev_vld_ff    <= ev_vld_in;
         busy_ff      <= busy_in;
         defd_ff      <= defd_in;
         best_vld_ff  <= best_vld_in;
         full_fit_ff  <= full_fit_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_cnt_ff    <= rd_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      ev_idx_ff    <= ev_idx_in;
      rmask_ff     <= rmask_in;
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
      best_base_ff <= best_base_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Never overwrite a beat that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while stalled");

   // Scan never runs past the table
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (32'(rd_cnt_ff) < 32'(NUM_PARTITIONS)))
      else $error("scan beyond last partition");

   // A granted partition is occupied afterwards
   a_grant_busy: assert property (@(posedge clock) disable iff (reset)
      grant |=> busy_ff[$past(best_idx_ff)])
      else $error("granted partition not marked busy");

   // Every reported release is free on finish
   a_release_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && is_release) |-> ((rmask_ff & busy_ff) == '0))
      else $error("released partition still busy");

endmodule

>>> tb/partition_table_checker.sv
`timescale 1ns / 1ps

module partition_table_checker #(
   parameter int NUM_SLOTS = bfpa_pkg::NUM_PARTITIONS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  bfpa_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  bfpa_pkg::rsp_type rsp_data,
   output int                outstanding,
   output int                fail_count
);
   import bfpa_pkg::*;

   // Shadow copy of the partition table
   logic [WORD_W-1:0] slot_size  [NUM_SLOTS];
   logic [WORD_W-1:0] slot_base  [NUM_SLOTS];
   logic              slot_taken [NUM_SLOTS];
   logic [PID_W-1:0]  slot_owner [NUM_SLOTS];

   // Outcomes still owed by the block, oldest first
   rsp_type pending_outcomes[$];

   task automatic flag_mismatch(input string what);
      $display("%0t allocator check failed: %s", $time, what);
      fail_count++;
   endtask

   // Apply one beat to the shadow table and work out the result it owes
   function automatic rsp_type allocator_outcome(input req_type item);
      rsp_type res;
      int      best;
      logic    busy_fit;
      res      = '0;
      best     = -1;
      busy_fit = 1'b0;
      case (item.opcode)
         OP_DEFINE: begin
            // size and base only; occupied flag and owner are left alone
            if (int'(item.partition_index) < NUM_SLOTS) begin
               slot_size[item.partition_index] = item.partition_size;
               slot_base[item.partition_index] = item.partition_base;
            end
         end
         OP_ALLOCATE: begin
            // smallest free slot that holds the request, lowest index on ties
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (item.request_size <= slot_size[i]) begin
                  if (slot_taken[i])
                     busy_fit = 1'b1;
                  else if (best < 0 || slot_size[i] < slot_size[best])
                     best = i;
               end
            end
            if (best >= 0) begin
               slot_taken[best]  = 1'b1;
               slot_owner[best]  = item.process_id;
               res.granted_index = PIDX_W'(best);
               res.granted_base  = slot_base[best];
            end else begin
               res.status = busy_fit ? ST_MEMORY_FULL : ST_TOO_BIG;
            end
         end
         OP_RELEASE: begin
            // free every slot held by this process
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_taken[i] && slot_owner[i] == item.process_id) begin
                  slot_taken[i] = 1'b0;
                  if (i < MASK_W)
                     res.released_mask[i] = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Match result beats against the oldest outcome, then log new request beats
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_size[i]  = '0;
            slot_base[i]  = '0;
            slot_taken[i] = 1'b0;
            slot_owner[i] = '0;
         end
         pending_outcomes.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               flag_mismatch($sformatf("result beat %h with nothing owed", rsp_data));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_data.status !== want.status)
                  flag_mismatch($sformatf("status got %0h expected %0h",
                                          rsp_data.status, want.status));
               if (rsp_data.granted_index !== want.granted_index)
                  flag_mismatch($sformatf("granted_index got %0h expected %0h",
                                          rsp_data.granted_index, want.granted_index));
               if (rsp_data.granted_base !== want.granted_base)
                  flag_mismatch($sformatf("granted_base got %0h expected %0h",
                                          rsp_data.granted_base, want.granted_base));
               if (rsp_data.released_mask !== want.released_mask)
                  flag_mismatch($sformatf("released_mask got %0h expected %0h",
                                          rsp_data.released_mask, want.released_mask));
            end
         end
         if (req_valid && req_ready)
            pending_outcomes.push_back(allocator_outcome(req_data));
      end
      outstanding <= pending_outcomes.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import bfpa_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASES          = 10;
   localparam int PHASE_BEATS     = 51;
   localparam int POOL_DEPTH      = 4;

   typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic req_taken = 1'b0;
   int   outstanding;
   int   fail_count;
   int   hold_offs_asked = 0;

   logic [WORD_W-1:0] defined_size [NUM_PARTITIONS_DEF];
   logic [PID_W-1:0]  pid_pool     [POOL_DEPTH];

   best_fit_partition_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   partition_table_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Note each request beat taken at the rising edge
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   function automatic req_type build_item(input logic [OP_W-1:0] op,
                                          input logic [PIDX_W-1:0] idx,
                                          input logic [WORD_W-1:0] psize,
                                          input logic [WORD_W-1:0] pbase,
                                          input logic [WORD_W-1:0] want,
                                          input logic [PID_W-1:0] pid);
      req_type item;
      item.opcode          = op;
      item.partition_index = idx;
      item.partition_size  = psize;
      item.partition_base  = pbase;
      item.request_size    = want;
      item.process_id      = pid;
      return item;
   endfunction

   // Random beat, biased towards sizes that hit the table's edges
   function automatic req_type random_item();
      req_type     item;
      logic [95:0] noise;
      int          pick;
      int          slot;
      noise = {$urandom, $urandom, $urandom};
      item  = noise[$bits(req_type)-1:0];
      pick  = $urandom_range(0, 99);
      slot  = $urandom_range(0, NUM_PARTITIONS_DEF - 1);
      if (pick < 25) begin
         item.opcode = OP_DEFINE;
         pick = $urandom_range(0, 99);
         if (pick < 40)
            item.partition_size = WORD_W'($urandom_range(0, 63));
         else if (pick < 55)
            item.partition_size = defined_size[slot];
         else if (pick < 65)
            item.partition_size = '1;
         else if (pick < 72)
            item.partition_size = '0;
      end else if (pick < 68) begin
         item.opcode = OP_ALLOCATE;
         if ($urandom_range(0, 9) != 0)
            item.process_id = pid_pool[$urandom_range(0, POOL_DEPTH - 1)];
         pick = $urandom_range(0, 99);
         if (pick < 40)
            item.request_size = defined_size[slot];
         else if (pick < 60)
            item.request_size = (defined_size[slot] > WORD_W'(3)) ?
                                defined_size[slot] - WORD_W'($urandom_range(1, 3)) : '0;
         else if (pick < 75)
            item.request_size = defined_size[slot] + WORD_W'(1);
         else if (pick < 85)
            item.request_size = '0;
      end else if (pick < 96) begin
         item.opcode = OP_RELEASE;
         if ($urandom_range(0, 9) != 0)
            item.process_id = pid_pool[$urandom_range(0, POOL_DEPTH - 1)];
      end else begin
         item.opcode = OP_UNUSED;
      end
      return item;
   endfunction

   // Hold the beat until it is taken
   task automatic offer_beat(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      if (item.opcode == OP_DEFINE)
         defined_size[item.partition_index] = item.partition_size;
      do @(negedge clock); while (!req_taken);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Receiver: stall patterns that change per window, plus long hold-offs on request
   initial begin : receiver
      rx_mode_type mode;
      int          window;
      int          holds_done;
      mode       = RX_OPEN;
      window     = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_done < hold_offs_asked) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         if (window == 0) begin
            mode   = rx_mode_type'($urandom_range(0, 3));
            window = $urandom_range(16, 96);
         end
         window--;
         case (mode)
            RX_OPEN:  rsp_ready <= 1'b1;
            RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:  rsp_ready <= (window % 5) < 2;
         endcase
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int sent;
      int burst;
      int gap;
      int gap_cap;
      foreach (defined_size[k]) defined_size[k] = '0;
      pid_pool[0] = 8'h00;
      pid_pool[1] = 8'hFF;
      pid_pool[2] = 8'h01;
      pid_pool[3] = 8'h80;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: zero request fits size-zero slots, anything larger is too big
      offer_beat(build_item(OP_ALLOCATE, 3'd0, '0, '0, 20'd0, 8'h00));
      offer_beat(build_item(OP_ALLOCATE, 3'd0, '0, '0, 20'd1, 8'h01));
      offer_beat(build_item(OP_ALLOCATE, 3'd0, '0, '0, 20'd0, 8'hFF));
      offer_beat(build_item(OP_RELEASE, 3'd0, '0, '0, '0, 8'h00));
      offer_beat(build_item(OP_RELEASE, 3'd0, '0, '0, '0, 8'hFF));
      // Extremes of size and base, and a tie between two slots
      offer_beat(build_item(OP_DEFINE, 3'd0, 20'hFFFFF, 20'hFFFFF, '0, '0));
      offer_beat(build_item(OP_DEFINE, 3'd7, 20'd100, 20'h00001, '0, '0));
      offer_beat(build_item(OP_DEFINE, 3'd3, 20'd100, 20'h12345, '0, '0));
      offer_beat(build_item(OP_DEFINE, 3'd5, 20'd0, 20'hABCDE, '0, '0));
      offer_beat(build_item(OP_ALLOCATE, 3'd0, '0, '0, 20'd50, 8'hAA));
      offer_beat(build_item(OP_ALLOCATE, 3'd0, '0, '0, 20'd100, 8'h55));
      offer_beat(build_item(OP_ALLOCATE, 3'd0, '0, '0, 20'd100, 8'h55));
      // Only an occupied slot would fit
      offer_beat(build_item(OP_ALLOCATE, 3'd0, '0, '0, 20'd101, 8'h55));
      // Redefine an occupied slot, then ask for more than any slot holds
      offer_beat(build_item(OP_DEFINE, 3'd0, 20'd10, 20'd0, '0, '0));
      offer_beat(build_item(OP_ALLOCATE, 3'd0, '0, '0, 20'hFFFFF, 8'h01));
      offer_beat(build_item(OP_ALLOCATE, 3'd0, '0, '0, 20'd0, 8'h01));
      offer_beat(build_item(OP_UNUSED, 3'h7, '1, '1, '1, 8'hFF));
      offer_beat(build_item(OP_RELEASE, 3'd0, '0, '0, '0, 8'h55));
      offer_beat(build_item(OP_RELEASE, 3'd0, '0, '0, '0, 8'h12));
      offer_beat(build_item(OP_DEFINE, 3'd6, 20'h80000, 20'h7FFFF, '0, '0));
      offer_beat(build_item(OP_DEFINE, 3'd4, 20'h7FFFF, 20'h80000, '0, '0));
      offer_beat(build_item(OP_ALLOCATE, 3'd0, '0, '0, 20'h7FFFF, 8'h80));
      offer_beat(build_item(OP_ALLOCATE, 3'd0, '0, '0, 20'h80000, 8'h7F));
      offer_beat(build_item(OP_RELEASE, 3'd0, '0, '0, '0, 8'h80));
      drain_results();

      // Random phases: bursts with gaps, a fresh set of owners each phase after the first
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0)
            foreach (pid_pool[k]) pid_pool[k] = PID_W'($urandom_range(0, 255));
         gap_cap = (phase % 3 == 0) ? 0 : $urandom_range(2, 10);
         if (phase == 4) begin
            // Starve the result side so the block backs up into the request side
            hold_offs_asked <= hold_offs_asked + 1;
            repeat (16) offer_beat(random_item());
         end
         sent = 0;
         while (sent < PHASE_BEATS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
               offer_beat(random_item());
               sent++;
            end
            gap = $urandom_range(0, gap_cap);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         if (phase % 4 == 3)
            drain_results();
      end

      drain_results();
      repeat (NUM_PARTITIONS_DEF + 8) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
hdl/bfpa_pkg.sv
hdl/bfpa_ctrl.sv
hdl/bfpa_dpath.sv
hdl/best_fit_partition_allocator.sv
tb/partition_table_checker.sv
tb/tb.sv
